/* sv/ipv4lpm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4lpm_pkg
// shared types and constants of the ipv4 longest prefix match forwarding block
// ----------------------------------------------------------------------------
package ipv4lpm_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W      = 32;
    localparam int LEN_W       = 6;
    localparam int SUM_W       = 20;
    localparam int CK_STEP_W   = 3;
    localparam int HDR_WORDS   = 5;

    localparam logic [CK_STEP_W-1:0] CK_FOLD1 = CK_STEP_W'(HDR_WORDS);
    localparam logic [CK_STEP_W-1:0] CK_FOLD2 = CK_STEP_W'(HDR_WORDS + 1);

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_FWD = 1'b1;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

    typedef enum logic [2:0] {
        ACT_FORWARD      = 3'd0,
        ACT_LOCAL        = 3'd1,
        ACT_DROP_TTL     = 3'd2,
        ACT_DROP_NOROUTE = 3'd3,
        ACT_ADDED        = 3'd4,
        ACT_FULL         = 3'd5
    } action_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_BUSY = 1'b1
    } state_t;

    typedef logic [HDR_WORDS-1:0][31:0] hdr_t;

    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] hop;
    } route_t;

    typedef struct packed {
        logic done;
        logic found;
    } scan_stat_t;

    typedef struct packed {
        logic        done;
        logic [15:0] cks;
    } ck_stat_t;

endpackage

/* sv/ipv4lpm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4lpm_ram
// generic single-clock ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module ipv4lpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/ipv4lpm_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4lpm_scan
// walks the route memory one entry a cycle and keeps the longest match
// ----------------------------------------------------------------------------
module ipv4lpm_scan (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [ipv4lpm_pkg::ADDR_W-1:0]        dest,
    input  logic [ipv4lpm_pkg::CNT_W-1:0]         count,
    input  ipv4lpm_pkg::route_t                   rd_data,
    output logic [ipv4lpm_pkg::IDX_W-1:0]         rd_addr,
    output ipv4lpm_pkg::scan_stat_t               stat,
    output logic [ipv4lpm_pkg::ADDR_W-1:0]        best_hop
);
    import ipv4lpm_pkg::*;

    logic              run_reg,  run_next;
    logic              rvld_reg, rvld_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [LEN_W-1:0]  best_len_reg, best_len_next;
    logic [ADDR_W-1:0] best_hop_reg, best_hop_next;
    logic [ADDR_W-1:0] mask;
    logic              issue;
    logic              hit;

    assign issue   = run_reg && (cnt_reg < count);
    assign rd_addr = cnt_reg[IDX_W-1:0];
    assign mask    = ~(32'hFFFF_FFFF >> rd_data.len);
    assign hit     = rvld_reg && (rd_data.len != '0) && (rd_data.len > best_len_reg)
                     && (((rd_data.prefix ^ dest) & mask) == '0);

    always_comb
    begin
        run_next      = run_reg;
        rvld_next     = issue;
        done_next     = done_reg;
        cnt_next      = cnt_reg;
        best_len_next = best_len_reg;
        best_hop_next = best_hop_reg;
        if (start)
        begin
            run_next      = 1'b1;
            rvld_next     = 1'b0;
            done_next     = 1'b0;
            cnt_next      = '0;
            best_len_next = '0;
            best_hop_next = '0;
        end
        else
        begin
            if (issue)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            if (hit)
            begin
                best_len_next = rd_data.len;
                best_hop_next = rd_data.hop;
            end
            if (run_reg && !issue && !rvld_reg)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg      <= 1'b0;
            rvld_reg     <= 1'b0;
            done_reg     <= 1'b0;
            cnt_reg      <= '0;
            best_len_reg <= '0;
        end
        else
        begin
            run_reg      <= run_next;
            rvld_reg     <= rvld_next;
            done_reg     <= done_next;
            cnt_reg      <= cnt_next;
            best_len_reg <= best_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_hop_reg <= best_hop_next;
    end

    assign stat.done  = done_reg;
    assign stat.found = (best_len_reg != '0);
    assign best_hop   = best_hop_reg;

`ifndef NO_ASSERTIONS
    a_scan_not_both : assert property (@(posedge clk) disable iff (!rst_n)
        !(run_reg && done_reg))
        else $error("scan running and done at once");
`endif

endmodule

/* sv/ipv4lpm_cksum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4lpm_cksum
// header checksum, one header word per cycle then two end-around folds
// ----------------------------------------------------------------------------
module ipv4lpm_cksum (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  ipv4lpm_pkg::hdr_t     hdr,
    output ipv4lpm_pkg::ck_stat_t stat
);
    import ipv4lpm_pkg::*;

    logic                 run_reg,  run_next;
    logic                 done_reg, done_next;
    logic [CK_STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]     acc_reg,  acc_next;
    logic [31:0]          word;
    logic [SUM_W-1:0]     folded;

    always_comb
    begin
        case (step_reg)
            3'd0:    word = hdr[0];
            3'd1:    word = hdr[1];
            3'd2:    word = hdr[2];
            3'd3:    word = hdr[3];
            3'd4:    word = hdr[4];
            default: word = '0;
        endcase
    end

    assign folded = SUM_W'(acc_reg[SUM_W-1:16]) + SUM_W'(acc_reg[15:0]);

    always_comb
    begin
        run_next  = run_reg;
        done_next = done_reg;
        step_next = step_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            run_next  = 1'b1;
            done_next = 1'b0;
            step_next = '0;
            acc_next  = '0;
        end
        else if (run_reg)
        begin
            step_next = step_reg + CK_STEP_W'(1);
            if (step_reg < CK_FOLD1)
            begin
                acc_next = acc_reg + SUM_W'(word[31:16]) + SUM_W'(word[15:0]);
            end
            else
            begin
                acc_next = folded;
                if (step_reg == CK_FOLD2)
                begin
                    run_next  = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign stat.done = done_reg;
    assign stat.cks  = ~acc_reg[15:0];

`ifndef NO_ASSERTIONS
    a_ck_folded : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (acc_reg[SUM_W-1:16] == '0))
        else $error("checksum not fully folded");
`endif

endmodule

/* sv/ipv4_lpm_forward.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_lpm_forward
// ipv4 longest prefix match forwarding with route table and ttl/checksum update
// ----------------------------------------------------------------------------
// Route adds, ttl drops and local deliveries finish in the cycle of the
// transaction and are offered on the output at the next edge. A routed lookup
// reads the route memory one entry a cycle through its single read port, once
// for each of the N stored routes (at most 64 with a full table), while the
// header checksum runs alongside. One transaction is worked on at a time; the
// output register lets a new transaction in while the previous result is
// being taken.
// ----------------------------------------------------------------------------
module ipv4_lpm_forward (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [31:0] route_prefix,
    input  logic [5:0]  route_length,
    input  logic [31:0] route_hop,
    input  logic [31:0] hdr_word0,
    input  logic [31:0] hdr_word1,
    input  logic [31:0] hdr_word2,
    input  logic [31:0] hdr_word3,
    input  logic [31:0] hdr_word4,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  action,
    output logic [31:0] next_hop,
    output logic [31:0] new_word2
);
    import ipv4lpm_pkg::*;

    state_t            state_reg, state_next;
    logic [31:0]       local_address_reg;
    logic [CNT_W-1:0]  entry_count_reg;
    hdr_t              hdr_reg;
    logic              out_valid_reg;
    action_t           action_reg, action_next;
    logic [31:0]       next_hop_reg, next_hop_next;
    logic [31:0]       new_word2_reg, new_word2_next;

    logic              in_accept;
    logic              out_free;
    logic              out_load;
    logic              start;
    logic              is_add;
    logic              full;
    logic              ttl_zero;
    logic              is_local;
    logic              immediate;
    logic              wr_en;
    logic              units_done;
    logic [7:0]        ttl_dec;
    route_t            wr_route;
    route_t            rd_route;
    logic [IDX_W-1:0]  rd_addr;
    scan_stat_t        scan_stat;
    ck_stat_t          ck_stat;
    logic [31:0]       best_hop;

    assign is_add     = (req_type == REQ_ADD);
    assign full       = (entry_count_reg == CNT_W'(TABLE_DEPTH));
    assign ttl_zero   = (hdr_word2[31:24] == 8'd0);
    assign is_local   = (hdr_word4 == local_address_reg);
    assign immediate  = is_add || ttl_zero || is_local;
    assign out_free   = !out_valid_reg || !out_stall;
    assign in_accept  = in_valid && !in_stall;
    assign wr_en      = in_accept && is_add && !full;
    assign units_done = scan_stat.done && ck_stat.done;
    assign ttl_dec    = hdr_word2[31:24] - 8'd1;

    assign wr_route.prefix = route_prefix;
    assign wr_route.len    = (route_length > MAX_LEN) ? MAX_LEN : route_length;
    assign wr_route.hop    = route_hop;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && !immediate)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (units_done && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall = 1'b1;
        start    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = immediate && !out_free;
                start    = in_valid && !in_stall && !immediate;
                out_load = in_valid && !in_stall && immediate;
            end
            ST_BUSY:
            begin
                out_load = units_done && out_free;
            end
            default: in_stall = 1'b1;
        endcase
    end

    // result
    always_comb
    begin
        action_next    = action_reg;
        next_hop_next  = next_hop_reg;
        new_word2_next = new_word2_reg;
        if (out_load)
        begin
            next_hop_next  = '0;
            new_word2_next = '0;
            if (state_reg == ST_BUSY)
            begin
                if (scan_stat.found)
                begin
                    action_next    = ACT_FORWARD;
                    next_hop_next  = best_hop;
                    new_word2_next = {hdr_reg[2][31:16], ck_stat.cks};
                end
                else
                begin
                    action_next = ACT_DROP_NOROUTE;
                end
            end
            else if (is_add)
            begin
                action_next = full ? ACT_FULL : ACT_ADDED;
            end
            else if (ttl_zero)
            begin
                action_next = ACT_DROP_TTL;
            end
            else
            begin
                action_next = ACT_LOCAL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            local_address_reg <= '0;
            entry_count_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                local_address_reg <= cfg_wr_data;
            end
            if (wr_en)
            begin
                entry_count_reg <= entry_count_reg + CNT_W'(1);
            end
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg    <= action_next;
        next_hop_reg  <= next_hop_next;
        new_word2_reg <= new_word2_next;
        if (start)
        begin
            hdr_reg[0] <= hdr_word0;
            hdr_reg[1] <= hdr_word1;
            hdr_reg[2] <= {ttl_dec, hdr_word2[23:16], 16'h0000};
            hdr_reg[3] <= hdr_word3;
            hdr_reg[4] <= hdr_word4;
        end
    end

    ipv4lpm_ram #(
        .WIDTH ($bits(route_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_route_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (entry_count_reg[IDX_W-1:0]),
        .wr_data (wr_route),
        .rd_addr (rd_addr),
        .rd_data (rd_route)
    );

    ipv4lpm_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .dest     (hdr_reg[4]),
        .count    (entry_count_reg),
        .rd_data  (rd_route),
        .rd_addr  (rd_addr),
        .stat     (scan_stat),
        .best_hop (best_hop)
    );

    ipv4lpm_cksum u_cksum (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .hdr   (hdr_reg),
        .stat  (ck_stat)
    );

    assign out_valid = out_valid_reg;
    assign action    = action_reg;
    assign next_hop  = next_hop_reg;
    assign new_word2 = new_word2_reg;

`ifndef NO_ASSERTIONS
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("route count beyond table depth");

    a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (entry_count_reg == $past(entry_count_reg) + CNT_W'(1)))
        else $error("route count not advanced after add");

    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("pending result overwritten");
`endif

endmodule

/* tb/ipv4_lpm_forward_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_lpm_forward_chk
// Watches the request and result channels of the forwarding block and keeps
// its own route table and local address. For each request it works out the
// forwarding decision and queues it. Each result is compared field by field
// with the oldest queued decision. The number of outstanding decisions and
// the number of mismatches are handed to the testbench top.
// ----------------------------------------------------------------------------
module ipv4_lpm_forward_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        req_type,
    input  logic [31:0] route_prefix,
    input  logic [5:0]  route_length,
    input  logic [31:0] route_hop,
    input  logic [31:0] hdr_word0,
    input  logic [31:0] hdr_word1,
    input  logic [31:0] hdr_word2,
    input  logic [31:0] hdr_word3,
    input  logic [31:0] hdr_word4,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  action,
    input  logic [31:0] next_hop,
    input  logic [31:0] new_word2,
    output int          pending,
    output int          errors
);
    import ipv4lpm_pkg::*;

    typedef struct packed {
        action_t     act;
        logic [31:0] hop;
        logic [31:0] word2;
    } fwd_result_t;

    logic [ADDR_W-1:0] rt_prefix [TABLE_DEPTH];
    logic [LEN_W-1:0]  rt_len    [TABLE_DEPTH];
    logic [ADDR_W-1:0] rt_hop    [TABLE_DEPTH];
    int                rt_used;
    logic [31:0]       local_addr;
    fwd_result_t       due_results [$];

    function automatic logic [15:0] hdr_cks(input hdr_t w);
        logic [31:0] acc;
        acc = 32'h0;
        for (int i = 0; i < HDR_WORDS; i++)
        begin
            acc += 32'(w[i][31:16]);
            if (i != 2)
                acc += 32'(w[i][15:0]);
        end
        while (acc > 32'hFFFF)
            acc = (acc >> 16) + (acc & 32'hFFFF);
        return ~acc[15:0];
    endfunction

    // works out the decision for a request and updates the route table on an add
    function automatic fwd_result_t route_decision(
        input logic        kind,
        input logic [31:0] pfx,
        input logic [5:0]  len,
        input logic [31:0] hop,
        input hdr_t        w
    );
        fwd_result_t r;
        logic [31:0] mask;
        logic [31:0] dest;
        logic [7:0]  ttl;
        int          best_len;
        r.act   = ACT_FORWARD;
        r.hop   = 32'h0;
        r.word2 = 32'h0;
        if (kind == REQ_ADD)
        begin
            if (rt_used >= TABLE_DEPTH)
                r.act = ACT_FULL;
            else
            begin
                rt_prefix[rt_used] = pfx;
                rt_len[rt_used]    = (len > MAX_LEN) ? MAX_LEN : len;
                rt_hop[rt_used]    = hop;
                rt_used++;
                r.act = ACT_ADDED;
            end
        end
        else
        begin
            ttl  = w[2][31:24];
            dest = w[4];
            if (ttl == 8'd0)
                r.act = ACT_DROP_TTL;
            else if (dest == local_addr)
                r.act = ACT_LOCAL;
            else
            begin
                best_len = 0;
                for (int k = 0; k < rt_used; k++)
                begin
                    if (rt_len[k] != '0 && int'(rt_len[k]) > best_len)
                    begin
                        mask = 32'hFFFF_FFFF << (32 - int'(rt_len[k]));
                        if ((rt_prefix[k] & mask) == (dest & mask))
                        begin
                            best_len = int'(rt_len[k]);
                            r.hop    = rt_hop[k];
                        end
                    end
                end
                if (best_len == 0)
                begin
                    r.act = ACT_DROP_NOROUTE;
                    r.hop = 32'h0;
                end
                else
                begin
                    w[2]    = {ttl - 8'd1, w[2][23:16], 16'h0};
                    r.word2 = w[2] | 32'(hdr_cks(w));
                    r.act   = ACT_FORWARD;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fwd_result_t want;
        int          n_bad;
        n_bad = 0;
        if (!rst_n)
        begin
            rt_used    = 0;
            local_addr = 32'h0;
            due_results.delete();
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                due_results.push_back(route_decision(req_type, route_prefix, route_length,
                    route_hop, {hdr_word4, hdr_word3, hdr_word2, hdr_word1, hdr_word0}));
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result with no transaction waiting: action %0d next_hop %h",
                        action, next_hop);
                    n_bad++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (action !== want.act)
                    begin
                        $error("action expected %0d actual %0d", want.act, action);
                        n_bad++;
                    end
                    if (next_hop !== want.hop)
                    begin
                        $error("next_hop expected %h actual %h", want.hop, next_hop);
                        n_bad++;
                    end
                    if (new_word2 !== want.word2)
                    begin
                        $error("new_word2 expected %h actual %h", want.word2, new_word2);
                        n_bad++;
                    end
                end
            end
            if (cfg_wr_en)
                local_addr = cfg_wr_data;
            pending <= due_results.size();
            errors  <= errors + n_bad;
        end
    end

endmodule

/* tb/ipv4_lpm_forward_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_lpm_forward_tb
// Drives route adds and packet headers into the forwarding block: a directed
// opening covering ttl expiry, local delivery, zero and oversized prefix
// lengths, equal-length ties and checksum extremes, then random phases under
// several local addresses with destinations mostly aimed at stored routes.
// The sender works in bursts, the receiver stalls on its own pattern, and a
// side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module ipv4_lpm_forward_tb;
    import ipv4lpm_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int PHASES       = 6;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        logic        kind;
        logic [31:0] pfx;
        logic [5:0]  len;
        logic [31:0] hop;
        hdr_t        hdr;
    } lpm_req_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [31:0] cfg_wr_data  = 32'h0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic        req_type     = REQ_ADD;
    logic [31:0] route_prefix = 32'h0;
    logic [5:0]  route_length = 6'h0;
    logic [31:0] route_hop    = 32'h0;
    logic [31:0] hdr_word0    = 32'h0;
    logic [31:0] hdr_word1    = 32'h0;
    logic [31:0] hdr_word2    = 32'h0;
    logic [31:0] hdr_word3    = 32'h0;
    logic [31:0] hdr_word4    = 32'h0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [2:0]  action;
    logic [31:0] next_hop;
    logic [31:0] new_word2;

    int          pending;
    int          errors;
    int          idle_cycles  = 0;
    int          burst_left   = 0;
    int          stall_mode   = 0;
    int          stall_span   = 0;
    int          stall_tick   = 0;
    logic [31:0] cur_local    = 32'h0;
    logic [31:0] added_pfx [$];
    logic [5:0]  added_len [$];

    always #5 clk = ~clk;

    ipv4_lpm_forward dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .route_prefix (route_prefix),
        .route_length (route_length),
        .route_hop    (route_hop),
        .hdr_word0    (hdr_word0),
        .hdr_word1    (hdr_word1),
        .hdr_word2    (hdr_word2),
        .hdr_word3    (hdr_word3),
        .hdr_word4    (hdr_word4),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .action       (action),
        .next_hop     (next_hop),
        .new_word2    (new_word2)
    );

    ipv4_lpm_forward_chk u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .route_prefix (route_prefix),
        .route_length (route_length),
        .route_hop    (route_hop),
        .hdr_word0    (hdr_word0),
        .hdr_word1    (hdr_word1),
        .hdr_word2    (hdr_word2),
        .hdr_word3    (hdr_word3),
        .hdr_word4    (hdr_word4),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .action       (action),
        .next_hop     (next_hop),
        .new_word2    (new_word2),
        .pending      (pending),
        .errors       (errors)
    );

    // receiver stall pattern, mode changes when its random span runs out
    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(30, 300);
        end
        else
            stall_span--;
        stall_tick++;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 1) == 1);
            2:       out_stall <= ((stall_tick % 16) < 9);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("ipv4_lpm_forward regression: fail");
        $finish;
    end

    function automatic logic [31:0] len_mask(input logic [5:0] l);
        if (l == 0)
            return 32'h0;
        if (l >= 32)
            return 32'hFFFF_FFFF;
        return 32'hFFFF_FFFF << (32 - l);
    endfunction

    function automatic lpm_req_t noise_req();
        lpm_req_t r;
        r.kind = 1'($urandom_range(0, 1));
        r.pfx  = $urandom;
        r.len  = 6'($urandom_range(0, 63));
        r.hop  = $urandom;
        for (int i = 0; i < HDR_WORDS; i++)
            r.hdr[i] = $urandom;
        return r;
    endfunction

    function automatic lpm_req_t add_req(input logic [31:0] p, input logic [5:0] l,
                                         input logic [31:0] h);
        lpm_req_t r;
        r      = noise_req();
        r.kind = REQ_ADD;
        r.pfx  = p;
        r.len  = l;
        r.hop  = h;
        return r;
    endfunction

    function automatic lpm_req_t fwd_req(input logic [7:0] ttl, input logic [31:0] dest);
        lpm_req_t r;
        r                = noise_req();
        r.kind           = REQ_FWD;
        r.hdr[2][31:24]  = ttl;
        r.hdr[4]         = dest;
        return r;
    endfunction

    function automatic lpm_req_t random_req();
        lpm_req_t    r;
        int          pick;
        int          k;
        logic [31:0] m;
        r    = noise_req();
        pick = $urandom_range(0, 99);
        if (pick < ((added_pfx.size() < TABLE_DEPTH) ? 30 : 8))
        begin
            r.kind = REQ_ADD;
            pick   = $urandom_range(0, 99);
            if (pick < 5)
                r.len = 6'd0;
            else if (pick < 10)
                r.len = 6'($urandom_range(33, 63));
            else
                r.len = 6'($urandom_range(1, 32));
            if (added_pfx.size() > 0)
            begin
                k    = $urandom_range(0, added_pfx.size() - 1);
                m    = len_mask(added_len[k]);
                pick = $urandom_range(0, 99);
                // same prefix and length as an earlier route: tie
                if (pick < 15)
                begin
                    r.pfx = added_pfx[k];
                    r.len = added_len[k];
                end
                else if (pick < 65)
                    r.pfx = (added_pfx[k] & m) | ($urandom & ~m);
            end
        end
        else
        begin
            r.kind = REQ_FWD;
            pick   = $urandom_range(0, 99);
            if (pick < 5)
                r.hdr[2][31:24] = 8'd0;
            else if (pick < 10)
                r.hdr[2][31:24] = 8'd1;
            else if (pick < 15)
                r.hdr[2][31:24] = 8'hFF;
            else
                r.hdr[2][31:24] = 8'($urandom_range(2, 254));
            pick = $urandom_range(0, 99);
            if (pick < 60 && added_pfx.size() > 0)
            begin
                k        = $urandom_range(0, added_pfx.size() - 1);
                m        = len_mask(added_len[k]);
                r.hdr[4] = (added_pfx[k] & m) | ($urandom & ~m);
            end
            else if (pick < 70)
                r.hdr[4] = cur_local;
        end
        return r;
    endfunction

    task automatic push_req(input lpm_req_t r);
        in_valid     <= 1'b1;
        req_type     <= r.kind;
        route_prefix <= r.pfx;
        route_length <= r.len;
        route_hop    <= r.hop;
        hdr_word0    <= r.hdr[0];
        hdr_word1    <= r.hdr[1];
        hdr_word2    <= r.hdr[2];
        hdr_word3    <= r.hdr[3];
        hdr_word4    <= r.hdr[4];
        do
            @(posedge clk);
        while (in_stall);
        if (r.kind == REQ_ADD && added_pfx.size() < TABLE_DEPTH)
        begin
            added_pfx.push_back(r.pfx);
            added_len.push_back(r.len);
        end
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic set_local(input logic [31:0] addr);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= addr;
        cur_local    = addr;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        lpm_req_t    r;
        logic [31:0] addr;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // local address still at its reset value
        push_req(fwd_req(8'd5, 32'h0));
        push_req(fwd_req(8'd0, 32'h0));
        push_req(fwd_req(8'd64, 32'h0A01_0203));

        push_req(add_req(32'hFFFF_FFFF, 6'd0, 32'h0000_0001));
        push_req(add_req(32'hC0A8_0101, 6'd63, 32'hC0A8_FFFE));
        push_req(add_req(32'h0A00_0000, 6'd8, 32'h0A00_00AA));
        push_req(add_req(32'h0A00_0000, 6'd8, 32'h0A00_00BB));
        push_req(add_req(32'h0A01_0000, 6'd16, 32'h0A01_0001));
        push_req(add_req(32'h0A01_0200, 6'd24, 32'hFFFF_FFFF));
        push_req(add_req(32'h8000_0000, 6'd1, 32'h0000_0000));
        push_req(add_req(32'h5A5A_5A5A, 6'd33, 32'h1234_5678));

        push_req(fwd_req(8'd1, 32'h0A01_0203));
        push_req(fwd_req(8'hFF, 32'h0A01_FF00));
        push_req(fwd_req(8'd17, 32'h0A99_0000));
        push_req(fwd_req(8'd2, 32'h9000_0000));
        push_req(fwd_req(8'd3, 32'h0000_0001));
        push_req(fwd_req(8'd128, 32'hC0A8_0101));
        r     = fwd_req(8'hFF, 32'hFFFF_FFFF);
        r.hdr = {HDR_WORDS{32'hFFFF_FFFF}};
        push_req(r);
        r               = fwd_req(8'd1, 32'h8000_0000);
        r.hdr           = '0;
        r.hdr[2][31:24] = 8'd1;
        r.hdr[4]        = 32'h8000_0000;
        push_req(r);

        set_local(32'hFFFF_FFFF);
        push_req(fwd_req(8'd9, 32'hFFFF_FFFF));
        push_req(fwd_req(8'd0, 32'hFFFF_FFFF));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       addr = 32'h0;
                2:       addr = 32'hFFFF_FFFF;
                3:       addr = (added_pfx.size() > 0)
                                ? added_pfx[$urandom_range(0, added_pfx.size() - 1)]
                                : $urandom;
                default: addr = $urandom;
            endcase
            set_local(addr);
            repeat (RANDOM_ITEMS / PHASES) push_req(random_req());
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("ipv4_lpm_forward regression: pass");
        else
            $display("ipv4_lpm_forward regression: fail");
        $finish;
    end

endmodule
